>>> rtl/dual_timer_counter_modes_macros.svh
// ----------------------------------------------------------------------------
// dual_timer_counter_modes_macros
// Assertion macros for the dual timer/counter block.
// ----------------------------------------------------------------------------
`ifndef DUAL_TIMER_COUNTER_MODES_MACROS_SVH
`define DUAL_TIMER_COUNTER_MODES_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DTC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtc assertion failed");

// next-cycle implication
`define DTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtc assertion failed");

`else

`define DTC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DTC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// Types, codes and the counter advance function of the dual timer/counter.
// ----------------------------------------------------------------------------
package dtc_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SEL_LOW0  = 2'd0,
      SEL_HIGH0 = 2'd1,
      SEL_LOW1  = 2'd2,
      SEL_HIGH1 = 2'd3
   } sel_type;

   typedef enum logic [1:0] {
      MODE_13BIT  = 2'd0,
      MODE_16BIT  = 2'd1,
      MODE_RELOAD = 2'd2,
      MODE_SPLIT  = 2'd3
   } mode_type;

   localparam int GATE0_BIT = 3;
   localparam int CTR0_BIT  = 2;
   localparam int GATE1_BIT = 7;
   localparam int CTR1_BIT  = 6;

   localparam logic [7:0] MODE_RESET = 8'h00;

   typedef struct packed {
      logic [7:0] lo;
      logic [7:0] hi;
      logic       ovf;
   } adv_type;

   function automatic adv_type advance(input logic [7:0] lo, input logic [7:0] hi,
                                       input mode_type mode, input logic [4:0] inc);
      logic [5:0] sum_pre;
      logic [8:0] sum;
      adv_type    res;
      sum_pre = {1'b0, lo[4:0]} + {1'b0, inc};
      sum     = {1'b0, lo} + {4'd0, inc};
      res.lo  = lo;
      res.hi  = hi;
      res.ovf = 1'b0;
      unique case (mode)
         MODE_13BIT: begin
            res.lo = {lo[7:5], sum_pre[4:0]};
            if (sum_pre[5]) begin
               res.hi  = hi + 8'd1;
               res.ovf = (hi == 8'hFF);
            end
         end
         MODE_16BIT: begin
            res.lo = sum[7:0];
            if (sum[8]) begin
               res.hi  = hi + 8'd1;
               res.ovf = (hi == 8'hFF);
            end
         end
         MODE_RELOAD: begin
            if (sum[8]) begin
               res.lo  = sum[7:0] + hi;
               res.ovf = 1'b1;
            end else begin
               res.lo = sum[7:0];
            end
         end
         MODE_SPLIT: begin
            res.lo  = sum[7:0];
            res.ovf = sum[8];
         end
      endcase
      return res;
   endfunction

endpackage

>>> rtl/dual_timer_counter_modes.sv
// ----------------------------------------------------------------------------
// dual_timer_counter_modes
// Two timer/counters with gate, counter select and four modes per timer.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per tick, byte write, flag clear or no-op (req_op).
//   rsp_*  : one transaction per request, the counter bytes and flags after
//            the step, plus the timer 1 stop request.
//   csr_*  : write of the mode register; always ready, write only when the
//            block has no pending response.
// A request that is accepted gives its registered response in the cycle
// after. Throughput is one request per cycle while no response waits, set by
// the single state update between the counter registers and themselves.
// The response register acts as the output stage: while rsp_ready is low
// and a response waits, req_ready is low; otherwise a request is taken
// every cycle, also in the cycle the waiting response leaves.
// Synchronous reset clears counters, flags, pin history, the mode register
// and the response valid; the block is ready in the first cycle after.
// ----------------------------------------------------------------------------
`include "dual_timer_counter_modes_macros.svh"

module dual_timer_counter_modes (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [4:0] req_elapsed_cycles,
   input  logic       req_run0,
   input  logic       req_run1,
   input  logic       req_int0_pin,
   input  logic       req_int1_pin,
   input  logic       req_t0_pin,
   input  logic       req_t1_pin,
   input  logic [1:0] req_byte_select,
   input  logic [7:0] req_write_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_low0,
   output logic [7:0] rsp_high0,
   output logic [7:0] rsp_low1,
   output logic [7:0] rsp_high1,
   output logic       rsp_flag0,
   output logic       rsp_flag1,
   output logic       rsp_stop_timer1
);

   logic [7:0] mode_ff;
   logic [7:0] count0_low_ff, count0_low_in, count0_high_ff, count0_high_in;
   logic [7:0] count1_low_ff, count1_low_in, count1_high_ff, count1_high_in;
   logic       overflow0_ff, overflow0_in, overflow1_ff, overflow1_in;
   logic       last_t0_ff, last_t0_in, last_t1_ff, last_t1_in;
   logic       stop_ff, stop_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   dtc_pkg::op_type   op;
   dtc_pkg::sel_type  sel;
   dtc_pkg::mode_type mode0, mode1;
   dtc_pkg::adv_type  adv0, adv1;
   logic              en0, en1, ctr0, ctr1, cnt0, cnt1;
   logic [4:0]        inc0, inc1;
   logic [8:0]        split_sum;
   logic [7:0]        high0_mid;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign op    = dtc_pkg::op_type'(req_op);
   assign sel   = dtc_pkg::sel_type'(req_byte_select);
   assign mode0 = dtc_pkg::mode_type'(mode_ff[1:0]);
   assign mode1 = dtc_pkg::mode_type'(mode_ff[5:4]);

   assign en0  = req_run0 && (!mode_ff[dtc_pkg::GATE0_BIT] || req_int0_pin);
   assign en1  = req_run1 && (!mode_ff[dtc_pkg::GATE1_BIT] || req_int1_pin);
   assign ctr0 = mode_ff[dtc_pkg::CTR0_BIT];
   assign ctr1 = mode_ff[dtc_pkg::CTR1_BIT];
   assign cnt0 = en0 && (!ctr0 || (last_t0_ff && !req_t0_pin));
   assign cnt1 = en1 && (!ctr1 || (last_t1_ff && !req_t1_pin));
   assign inc0 = ctr0 ? 5'd1 : req_elapsed_cycles;
   assign inc1 = ctr1 ? 5'd1 : req_elapsed_cycles;

   assign adv0 = dtc_pkg::advance(count0_low_ff, count0_high_ff, mode0, inc0);
   assign adv1 = dtc_pkg::advance(count1_low_ff, count1_high_ff, mode1, inc1);

   assign high0_mid = cnt0 ? adv0.hi : count0_high_ff;
   assign split_sum = {1'b0, high0_mid} + {4'd0, req_elapsed_cycles};

   always_comb begin
      count0_low_in  = count0_low_ff;
      count0_high_in = count0_high_ff;
      count1_low_in  = count1_low_ff;
      count1_high_in = count1_high_ff;
      overflow0_in   = overflow0_ff;
      overflow1_in   = overflow1_ff;
      last_t0_in     = last_t0_ff;
      last_t1_in     = last_t1_ff;
      stop_in        = 1'b0;
      unique case (op)
         dtc_pkg::OP_TICK: begin
            if (cnt0) begin
               count0_low_in  = adv0.lo;
               count0_high_in = adv0.hi;
               if (adv0.ovf) overflow0_in = 1'b1;
            end
            if (en0) last_t0_in = req_t0_pin;
            // split mode: high byte of timer 0 runs on timer 1's run bit
            if (mode0 == dtc_pkg::MODE_SPLIT && req_run1) begin
               count0_high_in = split_sum[7:0];
               if (split_sum[8]) overflow1_in = 1'b1;
            end
            if (cnt1) begin
               if (mode1 == dtc_pkg::MODE_SPLIT) begin
                  stop_in = 1'b1;
               end else begin
                  count1_low_in  = adv1.lo;
                  count1_high_in = adv1.hi;
                  if (adv1.ovf) overflow1_in = 1'b1;
               end
            end
            if (en1) last_t1_in = req_t1_pin;
         end
         dtc_pkg::OP_WRITE: begin
            unique case (sel)
               dtc_pkg::SEL_LOW0:  count0_low_in  = req_write_value;
               dtc_pkg::SEL_HIGH0: count0_high_in = req_write_value;
               dtc_pkg::SEL_LOW1:  count1_low_in  = req_write_value;
               dtc_pkg::SEL_HIGH1: count1_high_in = req_write_value;
            endcase
         end
         dtc_pkg::OP_CLEAR: begin
            if (req_write_value[0]) overflow0_in = 1'b0;
            if (req_write_value[1]) overflow1_in = 1'b0;
         end
         dtc_pkg::OP_NOP: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= dtc_pkg::MODE_RESET;
         count0_low_ff  <= 8'd0;
         count0_high_ff <= 8'd0;
         count1_low_ff  <= 8'd0;
         count1_high_ff <= 8'd0;
         overflow0_ff   <= 1'b0;
         overflow1_ff   <= 1'b0;
         last_t0_ff     <= 1'b0;
         last_t1_ff     <= 1'b0;
         stop_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) mode_ff <= csr_data;
         if (accept) begin
            count0_low_ff  <= count0_low_in;
            count0_high_ff <= count0_high_in;
            count1_low_ff  <= count1_low_in;
            count1_high_ff <= count1_high_in;
            overflow0_ff   <= overflow0_in;
            overflow1_ff   <= overflow1_in;
            last_t0_ff     <= last_t0_in;
            last_t1_ff     <= last_t1_in;
            stop_ff        <= stop_in;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_low0        = count0_low_ff;
   assign rsp_high0       = count0_high_ff;
   assign rsp_low1        = count1_low_ff;
   assign rsp_high1       = count1_high_ff;
   assign rsp_flag0       = overflow0_ff;
   assign rsp_flag1       = overflow1_ff;
   assign rsp_stop_timer1 = stop_ff;

   `DTC_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid)
   `DTC_ASSERT_IMPL(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `DTC_ASSERT_NEXT(a_no_stop_off_tick, clock, reset,
                    accept && req_op != dtc_pkg::OP_TICK, !rsp_stop_timer1)
   `DTC_ASSERT_NEXT(a_write_low0, clock, reset,
                    accept && req_op == dtc_pkg::OP_WRITE && req_byte_select == dtc_pkg::SEL_LOW0,
                    rsp_low0 == $past(req_write_value))

endmodule

>>> tb/dual_timer_counter_modes_tb.sv
// ----------------------------------------------------------------------------
// dual_timer_counter_modes_tb
// Self-checking testbench for the dual timer/counter. Directed items cover the
// prescaler wrap, flag set and clear, reload excess, split mode, counter edges
// and gating. Random traffic then runs across a range of mode settings and
// idle/stall mixes. A cycle-accurate predictor tracks both timers and checks
// every response transaction field by field.
// ----------------------------------------------------------------------------
module dual_timer_counter_modes_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SEGMENTS       = 16;
   localparam int SEGMENT_ITEMS  = 112;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] cyc;
      logic       run0;
      logic       run1;
      logic       int0;
      logic       int1;
      logic       t0;
      logic       t1;
      logic [1:0] sel;
      logic [7:0] val;
   } timer_req_type;

   typedef struct packed {
      logic [7:0] low0;
      logic [7:0] high0;
      logic [7:0] low1;
      logic [7:0] high1;
      logic       flag0;
      logic       flag1;
      logic       stop;
   } timer_snapshot_type;

   typedef struct packed {
      logic [7:0] lo;
      logic [7:0] hi;
      logic       carry;
   } byte_pair_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'h00;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_op = 2'd0;
   logic [4:0] req_elapsed_cycles = 5'd0;
   logic       req_run0 = 1'b0;
   logic       req_run1 = 1'b0;
   logic       req_int0_pin = 1'b0;
   logic       req_int1_pin = 1'b0;
   logic       req_t0_pin = 1'b0;
   logic       req_t1_pin = 1'b0;
   logic [1:0] req_byte_select = 2'd0;
   logic [7:0] req_write_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_low0;
   logic [7:0] rsp_high0;
   logic [7:0] rsp_low1;
   logic [7:0] rsp_high1;
   logic       rsp_flag0;
   logic       rsp_flag1;
   logic       rsp_stop_timer1;

   dual_timer_counter_modes dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_elapsed_cycles (req_elapsed_cycles),
      .req_run0           (req_run0),
      .req_run1           (req_run1),
      .req_int0_pin       (req_int0_pin),
      .req_int1_pin       (req_int1_pin),
      .req_t0_pin         (req_t0_pin),
      .req_t1_pin         (req_t1_pin),
      .req_byte_select    (req_byte_select),
      .req_write_value    (req_write_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_low0           (rsp_low0),
      .rsp_high0          (rsp_high0),
      .rsp_low1           (rsp_low1),
      .rsp_high1          (rsp_high1),
      .rsp_flag0          (rsp_flag0),
      .rsp_flag1          (rsp_flag1),
      .rsp_stop_timer1    (rsp_stop_timer1)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [7:0] mode_shadow;
   logic [7:0] cnt0_lo, cnt0_hi, cnt1_lo, cnt1_hi;
   logic       ovf0, ovf1, prev_t0, prev_t1;

   timer_snapshot_type expected_snapshots[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int recv_hold_left = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   function automatic byte_pair_type count_up(input logic [7:0] lo, input logic [7:0] hi,
                                              input dtc_pkg::mode_type md,
                                              input logic [4:0] inc);
      byte_pair_type r;
      int unsigned   s;
      r.lo    = lo;
      r.hi    = hi;
      r.carry = 1'b0;
      case (md)
         dtc_pkg::MODE_13BIT: begin
            s    = lo[4:0] + inc;
            r.lo = {lo[7:5], s[4:0]};
            if (s >= 32) begin
               r.hi    = hi + 8'd1;
               r.carry = (r.hi == 8'h00);
            end
         end
         dtc_pkg::MODE_16BIT: begin
            s    = lo + inc;
            r.lo = s[7:0];
            if (s >= 256) begin
               r.hi    = hi + 8'd1;
               r.carry = (r.hi == 8'h00);
            end
         end
         dtc_pkg::MODE_RELOAD: begin
            s = lo + inc;
            if (s >= 256) begin
               s       = s + hi;
               r.lo    = s[7:0];
               r.carry = 1'b1;
            end else begin
               r.lo = s[7:0];
            end
         end
         default: begin
            s       = lo + inc;
            r.lo    = s[7:0];
            r.carry = (s >= 256);
         end
      endcase
      return r;
   endfunction

   task automatic predict_step(input timer_req_type it);
      timer_snapshot_type snap;
      byte_pair_type      r;
      dtc_pkg::mode_type  md0, md1;
      logic               ctr;
      int unsigned        s;
      snap.stop = 1'b0;
      md0 = dtc_pkg::mode_type'(mode_shadow[1:0]);
      md1 = dtc_pkg::mode_type'(mode_shadow[5:4]);
      case (dtc_pkg::op_type'(it.op))
         dtc_pkg::OP_TICK: begin
            if (it.run0 && (!mode_shadow[dtc_pkg::GATE0_BIT] || it.int0)) begin
               ctr = mode_shadow[dtc_pkg::CTR0_BIT];
               if (!ctr || (prev_t0 && !it.t0)) begin
                  r = count_up(cnt0_lo, cnt0_hi, md0, ctr ? 5'd1 : it.cyc);
                  cnt0_lo = r.lo;
                  cnt0_hi = r.hi;
                  if (r.carry) ovf0 = 1'b1;
               end
               prev_t0 = it.t0;
            end
            // split mode: high byte of timer 0 runs on run1, ungated
            if (md0 == dtc_pkg::MODE_SPLIT && it.run1) begin
               s       = cnt0_hi + it.cyc;
               cnt0_hi = s[7:0];
               if (s >= 256) ovf1 = 1'b1;
            end
            if (it.run1 && (!mode_shadow[dtc_pkg::GATE1_BIT] || it.int1)) begin
               ctr = mode_shadow[dtc_pkg::CTR1_BIT];
               if (!ctr || (prev_t1 && !it.t1)) begin
                  if (md1 == dtc_pkg::MODE_SPLIT) begin
                     snap.stop = 1'b1;
                  end else begin
                     r = count_up(cnt1_lo, cnt1_hi, md1, ctr ? 5'd1 : it.cyc);
                     cnt1_lo = r.lo;
                     cnt1_hi = r.hi;
                     if (r.carry) ovf1 = 1'b1;
                  end
               end
               prev_t1 = it.t1;
            end
         end
         dtc_pkg::OP_WRITE: begin
            case (dtc_pkg::sel_type'(it.sel))
               dtc_pkg::SEL_LOW0:  cnt0_lo = it.val;
               dtc_pkg::SEL_HIGH0: cnt0_hi = it.val;
               dtc_pkg::SEL_LOW1:  cnt1_lo = it.val;
               default:            cnt1_hi = it.val;
            endcase
         end
         dtc_pkg::OP_CLEAR: begin
            if (it.val[0]) ovf0 = 1'b0;
            if (it.val[1]) ovf1 = 1'b0;
         end
         default: ;
      endcase
      snap.low0  = cnt0_lo;
      snap.high0 = cnt0_hi;
      snap.low1  = cnt1_lo;
      snap.high1 = cnt1_hi;
      snap.flag0 = ovf0;
      snap.flag1 = ovf1;
      expected_snapshots.push_back(snap);
   endtask

   task automatic check_response();
      timer_snapshot_type want;
      if (expected_snapshots.size() == 0) begin
         report_mismatch("response transaction with nothing pending");
      end else begin
         want = expected_snapshots.pop_front();
         if (rsp_low0 !== want.low0)
            report_mismatch($sformatf("low0 %0h want %0h", rsp_low0, want.low0));
         if (rsp_high0 !== want.high0)
            report_mismatch($sformatf("high0 %0h want %0h", rsp_high0, want.high0));
         if (rsp_low1 !== want.low1)
            report_mismatch($sformatf("low1 %0h want %0h", rsp_low1, want.low1));
         if (rsp_high1 !== want.high1)
            report_mismatch($sformatf("high1 %0h want %0h", rsp_high1, want.high1));
         if (rsp_flag0 !== want.flag0)
            report_mismatch($sformatf("flag0 %0b want %0b", rsp_flag0, want.flag0));
         if (rsp_flag1 !== want.flag1)
            report_mismatch($sformatf("flag1 %0b want %0b", rsp_flag1, want.flag1));
         if (rsp_stop_timer1 !== want.stop)
            report_mismatch($sformatf("stop_timer1 %0b want %0b", rsp_stop_timer1,
                                      want.stop));
      end
   endtask

   // scoreboard: responses are checked before the same edge's request is predicted
   always @(posedge clock) begin
      if (reset) begin
         mode_shadow = dtc_pkg::MODE_RESET;
         cnt0_lo = 8'h00;
         cnt0_hi = 8'h00;
         cnt1_lo = 8'h00;
         cnt1_hi = 8'h00;
         ovf0 = 1'b0;
         ovf1 = 1'b0;
         prev_t0 = 1'b0;
         prev_t1 = 1'b0;
      end else begin
         if (csr_valid && csr_ready) mode_shadow = csr_data;
         if (rsp_valid && rsp_ready) check_response();
         if (req_valid && req_ready)
            predict_step({req_op, req_elapsed_cycles, req_run0, req_run1, req_int0_pin,
                          req_int1_pin, req_t0_pin, req_t1_pin, req_byte_select,
                          req_write_value});
      end
   end

   always @(posedge clock) begin
      if (recv_hold_left > 0) begin
         rsp_ready <= 1'b0;
         recv_hold_left = recv_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready) || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_item(input timer_req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_op             <= it.op;
      req_elapsed_cycles <= it.cyc;
      req_run0           <= it.run0;
      req_run1           <= it.run1;
      req_int0_pin       <= it.int0;
      req_int1_pin       <= it.int1;
      req_t0_pin         <= it.t0;
      req_t1_pin         <= it.t1;
      req_byte_select    <= it.sel;
      req_write_value    <= it.val;
      req_valid          <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (expected_snapshots.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_mode(input logic [7:0] value);
      drain_results();
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idle(input int phase);
      case (phase)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
         default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
   endtask

   function automatic timer_req_type tick_item(input logic [4:0] cyc, input logic r0,
                                               input logic r1, input logic g0,
                                               input logic g1, input logic p0,
                                               input logic p1);
      timer_req_type it;
      it = '0;
      it.op = dtc_pkg::OP_TICK;
      it.cyc = cyc;
      it.run0 = r0;
      it.run1 = r1;
      it.int0 = g0;
      it.int1 = g1;
      it.t0 = p0;
      it.t1 = p1;
      return it;
   endfunction

   function automatic timer_req_type write_item(input dtc_pkg::sel_type sel,
                                                input logic [7:0] val);
      timer_req_type it;
      it = '0;
      it.op = dtc_pkg::OP_WRITE;
      it.sel = sel;
      it.val = val;
      return it;
   endfunction

   function automatic timer_req_type clear_item(input logic [7:0] val);
      timer_req_type it;
      it = '0;
      it.op = dtc_pkg::OP_CLEAR;
      it.val = val;
      return it;
   endfunction

   function automatic timer_req_type random_item();
      timer_req_type it;
      int pick;
      pick = $urandom_range(99);
      it.op   = (pick < 68) ? dtc_pkg::OP_TICK :
                (pick < 84) ? dtc_pkg::OP_WRITE :
                (pick < 95) ? dtc_pkg::OP_CLEAR : dtc_pkg::OP_NOP;
      pick = $urandom_range(9);
      it.cyc  = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd31 : 5'($urandom_range(31));
      it.run0 = ($urandom_range(9) != 0);
      it.run1 = ($urandom_range(9) != 0);
      it.int0 = 1'($urandom_range(1));
      it.int1 = 1'($urandom_range(1));
      it.t0   = 1'($urandom_range(1));
      it.t1   = 1'($urandom_range(1));
      it.sel  = 2'($urandom_range(3));
      // bias loads toward the top so overflows come often
      it.val  = ($urandom_range(3) == 0) ? 8'(8'hFF - $urandom_range(3))
                                         : 8'($urandom_range(255));
      return it;
   endfunction

   task automatic test_prescaler_overflow();
      set_mode(dtc_pkg::MODE_RESET);
      send_item({dtc_pkg::OP_NOP, 5'd31, 6'h3F, dtc_pkg::SEL_HIGH1, 8'hFF});
      send_item(tick_item(5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(write_item(dtc_pkg::SEL_LOW0, 8'hFF));
      send_item(write_item(dtc_pkg::SEL_HIGH0, 8'hFF));
      send_item(tick_item(5'd31, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(clear_item(8'h02));
      send_item(clear_item(8'h01));
   endtask

   task automatic test_flag_clear();
      send_item(write_item(dtc_pkg::SEL_HIGH1, 8'hFF));
      send_item(write_item(dtc_pkg::SEL_LOW1, 8'hFF));
      send_item(tick_item(5'd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(clear_item(8'hFF));
   endtask

   task automatic test_reload_excess();
      set_mode({2'b00, dtc_pkg::MODE_RELOAD, 2'b00, dtc_pkg::MODE_RELOAD});
      send_item(write_item(dtc_pkg::SEL_HIGH0, 8'hF0));
      send_item(write_item(dtc_pkg::SEL_LOW0, 8'hFA));
      send_item(write_item(dtc_pkg::SEL_HIGH1, 8'hFF));
      send_item(write_item(dtc_pkg::SEL_LOW1, 8'hFF));
      send_item(tick_item(5'd31, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(tick_item(5'd31, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
   endtask

   task automatic test_split_mode();
      set_mode({2'b00, dtc_pkg::MODE_SPLIT, 2'b00, dtc_pkg::MODE_SPLIT});
      send_item(write_item(dtc_pkg::SEL_HIGH0, 8'hFE));
      send_item(tick_item(5'd31, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(tick_item(5'd31, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
   endtask

   task automatic test_counter_gate();
      // gate and counter select on both timers, 13-bit mode
      set_mode(8'hCC);
      send_item(tick_item(5'd9, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(tick_item(5'd9, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
      send_item(tick_item(5'd9, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
      send_item(tick_item(5'd9, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(tick_item(5'd9, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(tick_item(5'd9, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
   endtask

   task automatic test_backpressure();
      set_mode(8'h11);
      set_idle(0);
      recv_hold_left = 150;
      repeat (16) send_item(random_item());
      drain_results();
   endtask

   task automatic test_random_traffic();
      logic [7:0] fixed_modes[6];
      fixed_modes = '{8'h00, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h44};
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         set_mode((seg < 6) ? fixed_modes[seg] : 8'($urandom_range(255)));
         set_idle(seg % 4);
         repeat (SEGMENT_ITEMS) send_item(random_item());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_idle(0);
      test_prescaler_overflow();
      test_flag_clear();
      test_reload_excess();
      test_split_mode();
      test_counter_gate();
      test_backpressure();
      test_random_traffic();
      drain_results();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
